// ----- sv/sms_pkg.sv -----
// Shared types, constants and helpers for the sliding median smoother.
package sms_pkg;

  localparam int DATA_W     = 32;
  localparam int WIN_W      = 5;
  localparam int HALF_W     = WIN_W - 1;
  localparam int CNT_W      = 6;
  localparam int AGE_W      = WIN_W;
  localparam int MAX_WINDOW = 31;
  localparam int NUM_CELLS  = MAX_WINDOW;
  localparam int CELL_IDX_W = $clog2(NUM_CELLS);
  localparam int RING_DEPTH = 32;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

  // Register map, indexed by word address.
  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0
  } sms_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] elevation_in;
    logic                     is_last;
  } sms_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] elevation_out;
    logic                     last_out;
  } sms_out_t;

  // One slot of the sorted window.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [AGE_W-1:0]         age;
  } sms_cell_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic seed;
  } sms_cell_ctl_t;

  localparam sms_cell_t EMPTY_CELL = '{valid: 1'b0, value: '0, age: '0};

  // A window of zero acts as one; anything above the chain length is clamped.
  function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (r == '0) begin
      r = WIN_W'(1);
    end
    if (r > WIN_W'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end
    return r;
  endfunction

endpackage

// ----- sv/sliding_median_smoother_unit.sv -----
// Sliding median smoother: top level with register port, sample ring and result emitter.
// Each track of elevation samples comes back with the same number of samples, in order:
// the first and last half-window samples pass through, the rest are medians of a window
// of window_size samples (upper middle for even sizes), and a track of at most
// window_size samples passes through untouched. window_size is taken at the first sample
// of each track. Results are held until the track reaches window_size+1 samples or ends,
// then go out as a burst, one beat per cycle while the output side keeps up. A sample
// is accepted only while no burst is going out, and the 31-cell sorting row updates in
// that same cycle; the emitter then sends the results of that sample in turn, up to 32
// when it starts or ends a burst. The result register lets a new sample in while the
// last beat still waits. There is no clearing pass after reset.
module sliding_median_smoother_unit import sms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sms_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sms_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;

  // Register port.
  logic [WIN_W-1:0] window_size;
  sms_reg_t         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = sms_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr && (reg_sel == REG_WINDOW_SIZE)) begin
      window_size <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_SIZE: prdata = PDATA_W'(window_size);
      default:         prdata = '0;
    endcase
  end

  // Track state and burst plan.
  logic [WIN_W-1:0]      win_latched;
  logic [CNT_W-1:0]      count;
  logic                  settled;
  logic [WIN_W-1:0]      a_cnt;
  logic [RING_IDX_W-1:0] a_ptr;
  logic                  mp;
  logic                  mc;
  logic [HALF_W-1:0]     b_cnt;
  logic [RING_IDX_W-1:0] b_ptr;
  logic                  burst_last;

  logic                  accept;
  logic                  track_start;
  logic [WIN_W-1:0]      w_eff;
  logic [HALF_W-1:0]     h_eff;
  logic                  settle_now;
  logic                  is_last;
  logic [WIN_W-1:0]      pa_cnt;
  logic                  pmp;
  logic                  pmc;
  logic [HALF_W-1:0]     pb_cnt;
  logic [CNT_W-1:0]      b_start;
  logic                  plan_any;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign is_last     = in_data.is_last;
  assign track_start = !settled && (count == '0);
  assign w_eff       = track_start ? clamp_window(window_size) : win_latched;
  assign h_eff       = w_eff[WIN_W-1:1];
  assign settle_now  = !settled && (count == CNT_W'(w_eff));
  assign b_start     = count - CNT_W'(h_eff) + CNT_W'(1);

  // Odd windows take the median of the window ending at the newest sample; even ones that of the window before it.
  always_comb begin
    pa_cnt = '0;
    pmp    = 1'b0;
    pmc    = 1'b0;
    pb_cnt = '0;
    priority if (settled) begin
      pmp = !w_eff[0];
      pmc = w_eff[0];
      if (is_last) begin
        pb_cnt = h_eff;
      end
    end else if (settle_now) begin
      pa_cnt = WIN_W'(h_eff);
      pmp    = 1'b1;
      pmc    = w_eff[0];
      if (is_last) begin
        pb_cnt = h_eff;
      end
    end else if (is_last) begin
      pa_cnt = count[WIN_W-1:0] + WIN_W'(1);
    end
  end

  assign plan_any = (pa_cnt != '0) || pmp || pmc || (pb_cnt != '0);

  // Sorted window.
  logic signed [DATA_W-1:0] med_cur;
  logic signed [DATA_W-1:0] med_prev;
  logic [NUM_CELLS-1:0]     cell_valid;

  sms_sort_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .clear      (track_start),
    .del_en     (settled || settle_now),
    .del_age    (w_eff - WIN_W'(1)),
    .x          (in_data.elevation_in),
    .med_sel    (CELL_IDX_W'(win_latched[WIN_W-1:1])),
    .med        (med_cur),
    .cell_valid (cell_valid)
  );

  // Raw samples for the pass-through parts; med_prev keeps the median of the window
  // that ended one sample earlier.
  logic signed [DATA_W-1:0] ring [RING_DEPTH];
  logic [RING_IDX_W-1:0]    rd_addr;
  logic signed [DATA_W-1:0] ring_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[count[RING_IDX_W-1:0]] <= in_data.elevation_in;
      med_prev                    <= med_cur;
    end
  end

  assign rd_addr = (a_cnt != '0) ? a_ptr : b_ptr;
  assign ring_q  = ring[rd_addr];

  // Emitter.
  logic                     slot_free;
  logic                     issue;
  logic [CNT_W-1:0]         remaining;
  logic                     final_beat;
  logic signed [DATA_W-1:0] beat_val;

  assign slot_free  = !out_valid || out_ready;
  assign issue      = (state == S_EMIT) && slot_free;
  assign remaining  = CNT_W'(a_cnt) + CNT_W'(mp) + CNT_W'(mc) + CNT_W'(b_cnt);
  assign final_beat = (remaining == CNT_W'(1));

  always_comb begin
    priority if (a_cnt != '0) begin
      beat_val = ring_q;
    end else if (mp) begin
      beat_val = med_prev;
    end else if (mc) begin
      beat_val = med_cur;
    end else begin
      beat_val = ring_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win_latched <= WINDOW_RESET;
      count       <= '0;
      settled     <= 1'b0;
      a_cnt       <= '0;
      mp          <= 1'b0;
      mc          <= 1'b0;
      b_cnt       <= '0;
      burst_last  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            win_latched <= w_eff;
            if (is_last) begin
              count   <= '0;
              settled <= 1'b0;
            end else begin
              count <= count + CNT_W'(1);
              if (settle_now) begin
                settled <= 1'b1;
              end
            end
            a_cnt      <= pa_cnt;
            a_ptr      <= '0;
            mp         <= pmp;
            mc         <= pmc;
            b_cnt      <= pb_cnt;
            b_ptr      <= b_start[RING_IDX_W-1:0];
            burst_last <= is_last;
            if (plan_any) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            out_data.elevation_out <= beat_val;
            out_data.last_out      <= burst_last && final_beat;
            priority if (a_cnt != '0) begin
              a_cnt <= a_cnt - WIN_W'(1);
              a_ptr <= a_ptr + RING_IDX_W'(1);
            end else if (mp) begin
              mp <= 1'b0;
            end else if (mc) begin
              mc <= 1'b0;
            end else begin
              b_cnt <= b_cnt - HALF_W'(1);
              b_ptr <= b_ptr + RING_IDX_W'(1);
            end
            if (final_beat) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (a_cnt != '0) || mp || mc || (b_cnt != '0))
    else $error("emitter busy with an empty plan");

  a_last_ends_track: assert property (@(posedge clk) disable iff (rst)
    (issue && burst_last && final_beat) |-> (count == '0) && !settled)
    else $error("final beat of a track while the track is still open");

  a_window_full: assert property (@(posedge clk) disable iff (rst)
    settled |-> ($countones(cell_valid) == int'(win_latched)))
    else $error("sorted window does not hold a full window");

endmodule

// ----- sv/sms_cell.sv -----
// One slot of the sorted window: keeps its sample or takes a neighbor's or the new one.
module sms_cell import sms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  sms_cell_ctl_t            ctl,
  input  logic signed [DATA_W-1:0] x,
  input  logic                     del_en,
  input  logic [AGE_W-1:0]         del_age,
  input  sms_cell_t                low,
  input  logic                     low_gt,
  input  sms_cell_t                up,
  input  logic                     up_gt,
  input  logic                     del_below,
  output sms_cell_t                q,
  output logic                     gt,
  output logic                     del_out
);

  typedef enum logic [1:0] {
    SRC_SELF,
    SRC_LOW,
    SRC_UP,
    SRC_X
  } src_t;

  src_t      src;
  sms_cell_t nxt;
  logic      del_self;

  assign del_self = del_en && q.valid && (q.age == del_age);
  // An empty slot counts as larger than any sample.
  assign gt       = !q.valid || ($signed(x) < $signed(q.value));
  assign del_out  = del_below || del_self;

  // Below the leaving sample the row shifts up to make room; from it on, down.
  always_comb begin
    priority if (!del_out) begin
      priority if (!gt) begin
        src = SRC_SELF;
      end else if (!low_gt) begin
        src = SRC_X;
      end else begin
        src = SRC_LOW;
      end
    end else if (del_self) begin
      priority if (!up_gt) begin
        src = SRC_UP;
      end else if (low_gt) begin
        src = SRC_LOW;
      end else begin
        src = SRC_X;
      end
    end else begin
      priority if (!up_gt) begin
        src = SRC_UP;
      end else if (!gt) begin
        src = SRC_X;
      end else begin
        src = SRC_SELF;
      end
    end
  end

  always_comb begin
    unique case (src)
      SRC_SELF: nxt = '{valid: q.valid, value: q.value, age: q.age + AGE_W'(1)};
      SRC_LOW:  nxt = '{valid: low.valid, value: low.value, age: low.age + AGE_W'(1)};
      SRC_UP:   nxt = '{valid: up.valid, value: up.value, age: up.age + AGE_W'(1)};
      SRC_X:    nxt = '{valid: 1'b1, value: x, age: '0};
      default:  nxt = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (ctl.en) begin
      if (ctl.clear) begin
        q.valid <= ctl.seed;
        q.value <= x;
        q.age   <= '0;
      end else begin
        q <= nxt;
      end
    end
  end

endmodule

// ----- sv/sms_sort_chain.sv -----
// Row of cells holding the current window in sorted order, with median readout.
module sms_sort_chain import sms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     clear,
  input  logic                     del_en,
  input  logic [AGE_W-1:0]         del_age,
  input  logic signed [DATA_W-1:0] x,
  input  logic [CELL_IDX_W-1:0]    med_sel,
  output logic signed [DATA_W-1:0] med,
  output logic [NUM_CELLS-1:0]     cell_valid
);

  sms_cell_t            cells [NUM_CELLS];
  logic [NUM_CELLS-1:0] gt;
  logic [NUM_CELLS:0]   del_chain;

  assign del_chain[0] = 1'b0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sms_cell_t     low_c;
    sms_cell_t     up_c;
    logic          low_gt;
    logic          up_gt;
    sms_cell_ctl_t ctl;

    if (k == 0) begin : g_bottom
      assign low_c  = EMPTY_CELL;
      assign low_gt = 1'b0;
    end else begin : g_low
      assign low_c  = cells[k-1];
      assign low_gt = gt[k-1];
    end

    if (k == NUM_CELLS - 1) begin : g_top
      assign up_c  = EMPTY_CELL;
      assign up_gt = 1'b1;
    end else begin : g_up
      assign up_c  = cells[k+1];
      assign up_gt = gt[k+1];
    end

    // On the first sample of a track the bottom cell takes it and the rest empty out.
    assign ctl = '{en: en, clear: clear, seed: (k == 0)};

    sms_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .x         (x),
      .del_en    (del_en),
      .del_age   (del_age),
      .low       (low_c),
      .low_gt    (low_gt),
      .up        (up_c),
      .up_gt     (up_gt),
      .del_below (del_chain[k]),
      .q         (cells[k]),
      .gt        (gt[k]),
      .del_out   (del_chain[k+1])
    );

    assign cell_valid[k] = cells[k].valid;
  end

  assign med = cells[med_sel].value;

  for (genvar k = 0; k < NUM_CELLS - 1; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cells[k+1].valid |-> cells[k].valid && (cells[k].value <= cells[k+1].value))
      else $error("sort chain out of order or has a gap");
  end

endmodule

// ----- bench/sliding_median_smoother_unit_tb.sv -----
// Self-checking testbench for the sliding median smoother unit.
`timescale 1ns / 1ps

module sliding_median_smoother_unit_tb;
  import sms_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [DATA_W-1:0] ELEV_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ELEV_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(4 * int'(REG_WINDOW_SIZE));

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sms_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sms_out_t           out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sliding_median_smoother_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Samples waiting to be offered, and the smoothed results still owed by the block.
  sms_in_t  pend_q[$];
  sms_out_t smoothed_q[$];

  int  queued_cnt = 0;
  int  accepted_cnt = 0;
  int  checked_cnt = 0;
  int  track_cnt = 0;
  int  window_writes = 0;
  int  err_cnt = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  bit  in_took = 1'b0;

  // Mirror of the smoother state.
  logic signed [DATA_W-1:0] elev_ring [RING_DEPTH];
  logic [CNT_W-1:0]         seen_cnt;
  logic [CNT_W-1:0]         emit_idx;
  logic                     settled;
  logic [WIN_W-1:0]         win_in_use;
  logic [WIN_W-1:0]         win_reg;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic open_track();
    seen_cnt = '0;
    emit_idx = '0;
    settled  = 1'b0;
  endtask

  task automatic push_result(input logic signed [DATA_W-1:0] v, input logic lst);
    sms_out_t t;
    t.elevation_out = v;
    t.last_out      = lst;
    smoothed_q.push_back(t);
  endtask

  // Element h of the sorted window that is centered on result index idx.
  function automatic logic signed [DATA_W-1:0] median_at(input logic [CNT_W-1:0] idx,
                                                         input int w);
    logic signed [DATA_W-1:0] srt [RING_DEPTH];
    logic signed [DATA_W-1:0] v;
    logic [CNT_W-1:0]         first;
    int                       h, m, k;
    h = w >> 1;
    first = CNT_W'(int'(idx) - h);
    for (m = 0; m < w; m++) begin
      v = elev_ring[(int'(first) + m) % RING_DEPTH];
      k = m;
      while (k > 0 && v < srt[k-1]) begin
        srt[k] = srt[k-1];
        k--;
      end
      srt[k] = v;
    end
    return srt[h];
  endfunction

  task automatic smooth_sample(input sms_in_t it);
    sms_out_t         t;
    logic [CNT_W-1:0] rem;
    int               jn, w, h, i;
    if (seen_cnt == '0 && !settled) begin
      win_in_use = (win_reg == '0) ? WIN_W'(1) : win_reg;
    end
    w  = int'(win_in_use);
    h  = w >> 1;
    jn = int'(seen_cnt);
    elev_ring[jn % RING_DEPTH] = it.elevation_in;
    seen_cnt = seen_cnt + CNT_W'(1);
    if (!settled) begin
      if (jn == w) begin
        // The track is now longer than the window: release the leading part.
        settled = 1'b1;
        for (i = 0; i <= jn - h; i++) begin
          push_result((i < h) ? elev_ring[i] : median_at(CNT_W'(i), w), 1'b0);
        end
        emit_idx = CNT_W'(jn - h + 1);
      end else if (!it.is_last) begin
        return;
      end else begin
        for (i = 0; i <= jn; i++) begin
          push_result(elev_ring[i], i == jn);
        end
        open_track();
        return;
      end
    end else begin
      push_result(median_at(emit_idx, w), 1'b0);
      emit_idx = emit_idx + CNT_W'(1);
    end
    if (it.is_last) begin
      rem = CNT_W'(jn - int'(emit_idx) + 1);
      for (i = 0; i < int'(rem); i++) begin
        push_result(elev_ring[(int'(emit_idx) + i) % RING_DEPTH], 1'b0);
      end
      t = smoothed_q.pop_back();
      t.last_out = 1'b1;
      smoothed_q.push_back(t);
      open_track();
    end
  endtask

  // Monitor: register writes, accepted samples and result beats, all at the rising edge.
  always @(posedge clk) begin
    sms_out_t t;
    if (rst) begin
      foreach (elev_ring[n]) elev_ring[n] = '0;
      win_reg    = WINDOW_RESET;
      win_in_use = WINDOW_RESET;
      open_track();
      in_took = 1'b0;
    end else begin
      in_took = in_valid && in_ready;
      // A sample taken at the same edge as a register write still sees the old window.
      if (in_took) begin
        accepted_cnt++;
        if (in_data.is_last) track_cnt++;
        smooth_sample(in_data);
      end
      if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR) begin
        win_reg = pwdata[WIN_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (smoothed_q.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d / %0b with nothing expected",
                                  out_data.elevation_out, out_data.last_out));
        end else begin
          t = smoothed_q.pop_front();
          checked_cnt++;
          if (out_data.elevation_out !== t.elevation_out) begin
            flag_mismatch($sformatf("elevation_out %0d, expected %0d",
                                    out_data.elevation_out, t.elevation_out));
          end
          if (out_data.last_out !== t.last_out) begin
            flag_mismatch($sformatf("last_out %0b, expected %0b",
                                    out_data.last_out, t.last_out));
          end
        end
      end
    end
  end

  // Sample driver: holds a beat until it is taken, then offers the next one or idles.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic add_sample(input logic signed [DATA_W-1:0] v, input logic lst);
    sms_in_t t;
    t.elevation_in = v;
    t.is_last      = lst;
    pend_q.push_back(t);
    queued_cnt++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_elev();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1, 2: v = DATA_W'(int'($urandom_range(16)) - 8);
      default: begin
        case ($urandom_range(3))
          0: v = ELEV_MIN;
          1: v = ELEV_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_track(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      add_sample(pick_elev(), i == len - 1);
    end
  endtask

  // Whole tracks whose lengths straddle the window: short pass-through, just past it, long.
  task automatic random_tracks(input int win, input int budget);
    int eff, n, len;
    eff = (win == 0) ? 1 : win;
    n = 0;
    while (n < budget) begin
      case ($urandom_range(7))
        0, 1: len = $urandom_range(eff, 1);
        2, 3, 4, 5: len = $urandom_range(eff + 4, eff + 1);
        default: len = $urandom_range(2 * eff + 6, eff + 1);
      endcase
      add_track(len);
      n += len;
    end
  endtask

  task automatic set_idle(input int src, input int snk);
    @(posedge clk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // Waits until every sample is taken and every result has come, then lets the block settle.
  task automatic settle_block();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || smoothed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_ADDR;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    window_writes++;
  endtask

  task automatic new_phase(input int win, input int src, input int snk);
    settle_block();
    write_window(win);
    set_idle(src, snk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, window at its reset value of 3.
    @(posedge clk);
    add_sample(ELEV_MAX, 1'b0);
    add_sample(ELEV_MIN, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(5, 1'b1);
    add_sample(-1, 1'b1);
    add_sample(10, 1'b0);
    add_sample(-20, 1'b0);
    add_sample(30, 1'b1);
    add_sample(1, 1'b0);
    add_sample(2, 1'b0);
    add_sample(3, 1'b0);
    add_sample(4, 1'b1);
    add_sample(100, 1'b0);
    add_sample(-100, 1'b0);
    // A window change in the middle of a track only applies from the next track on.
    settle_block();
    write_window(0);
    @(posedge clk);
    add_sample(50, 1'b0);
    add_sample(ELEV_MIN, 1'b0);
    add_sample(70, 1'b1);
    add_sample(9, 1'b0);
    add_sample(8, 1'b1);

    // Long track wraps the counters; the result side holds off while samples keep coming.
    new_phase(2, 0, 58);
    add_track(65);
    hold_req++;

    // Largest window: a track of window+1 samples ends with a 32-beat burst.
    new_phase(31, 58, 0);
    add_track(32);

    new_phase(4, 8, 8);
    random_tracks(4, 6);

    settle_block();
    $display("Run covered %0d samples in %0d tracks, %0d result beats checked,",
             accepted_cnt, track_cnt, checked_cnt);
    $display("under %0d window settings with idle, stall and hold-off phases.",
             window_writes + 1);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Timed out with %0d results still expected.", smoothed_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
